@@ hw/rtl/bpc_pkg.sv @@
// Package for the button press classifier: request types, configuration
// record, register indexes, gesture codes and reset values. No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPAN_W  = 16;
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_LONG      = 3'd1,
        REG_RPT_DELAY = 3'd2,
        REG_RPT_INTV  = 3'd3,
        REG_RPT_EN    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SHORT  = 2'd1,
        GEST_LONG   = 2'd2,
        GEST_REPEAT = 2'd3
    } t_gesture;

    localparam logic [SPAN_W-1:0] RST_DEBOUNCE  = 16'd30;
    localparam logic [SPAN_W-1:0] RST_LONG      = 16'd600;
    localparam logic [SPAN_W-1:0] RST_RPT_DELAY = 16'd300;
    localparam logic [SPAN_W-1:0] RST_RPT_INTV  = 16'd100;
    localparam logic              RST_RPT_EN    = 1'b1;

    typedef struct packed {
        logic              level_sample;
        logic [TIME_W-1:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic [1:0] gesture_code;
        logic       held_level;
    } t_out_req;

    typedef struct packed {
        logic [SPAN_W-1:0] debounce_time;
        logic [SPAN_W-1:0] long_press_time;
        logic [SPAN_W-1:0] repeat_delay;
        logic [SPAN_W-1:0] repeat_interval;
        logic              repeat_enable;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/bpc_cfg.sv @@
// APB-style configuration registers of the button press classifier.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg
    import bpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= RST_DEBOUNCE;
            r_cfg.long_press_time <= RST_LONG;
            r_cfg.repeat_delay    <= RST_RPT_DELAY;
            r_cfg.repeat_interval <= RST_RPT_INTV;
            r_cfg.repeat_enable   <= RST_RPT_EN;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE:  r_cfg.debounce_time   <= pwdata[SPAN_W-1:0];
                REG_LONG:      r_cfg.long_press_time <= pwdata[SPAN_W-1:0];
                REG_RPT_DELAY: r_cfg.repeat_delay    <= pwdata[SPAN_W-1:0];
                REG_RPT_INTV:  r_cfg.repeat_interval <= pwdata[SPAN_W-1:0];
                REG_RPT_EN:    r_cfg.repeat_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_DEBOUNCE:  prdata = {{(PDATA_W-SPAN_W){1'b0}}, r_cfg.debounce_time};
            REG_LONG:      prdata = {{(PDATA_W-SPAN_W){1'b0}}, r_cfg.long_press_time};
            REG_RPT_DELAY: prdata = {{(PDATA_W-SPAN_W){1'b0}}, r_cfg.repeat_delay};
            REG_RPT_INTV:  prdata = {{(PDATA_W-SPAN_W){1'b0}}, r_cfg.repeat_interval};
            REG_RPT_EN:    prdata = {{(PDATA_W-1){1'b0}}, r_cfg.repeat_enable};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/bpc_classify.sv @@
// Debounce and gesture state with the single-step classification logic.
// Depends on bpc_pkg.
`default_nettype none

module bpc_classify
    import bpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  t_in_req      i_req,
    input  t_cfg         i_cfg,
    output t_out_req     o_res
);

    logic              r_raw, n_raw;
    logic [TIME_W-1:0] r_chg_t, n_chg_t;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_press_t, n_press_t;
    logic              r_long_sent, n_long_sent;
    logic [TIME_W-1:0] r_next_rpt, n_next_rpt;

    logic [TIME_W-1:0] w_now;
    logic              w_changed;
    logic              w_deb_ok;
    logic              w_accept;
    logic              w_long_ok;
    logic              w_rpt_ok;
    logic [TIME_W-1:0] w_chg_diff;
    logic [TIME_W-1:0] w_press_diff;
    logic [TIME_W-1:0] w_rpt_diff;
    logic [SPAN_W:0]   w_first_ofs;
    t_gesture          w_code;

    assign w_now        = i_req.now_ms;
    assign w_changed    = i_req.level_sample != r_raw;
    assign w_chg_diff   = w_now - r_chg_t;
    assign w_press_diff = w_now - r_press_t;
    assign w_rpt_diff   = w_now - r_next_rpt;
    assign w_first_ofs  = {1'b0, i_cfg.long_press_time} + {1'b0, i_cfg.repeat_delay};

    // a fresh raw change has zero elapsed time
    assign w_deb_ok  = w_changed ? (i_cfg.debounce_time == '0)
                                 : (w_chg_diff >= {{(TIME_W-SPAN_W){1'b0}}, i_cfg.debounce_time});
    assign w_accept  = (i_req.level_sample != r_stable) && w_deb_ok;
    assign w_long_ok = w_press_diff >= {{(TIME_W-SPAN_W){1'b0}}, i_cfg.long_press_time};
    assign w_rpt_ok  = !w_rpt_diff[TIME_W-1];

    always_comb begin
        n_raw       = i_req.level_sample;
        n_chg_t     = w_changed ? w_now : r_chg_t;
        n_stable    = r_stable;
        n_press_t   = r_press_t;
        n_long_sent = r_long_sent;
        n_next_rpt  = r_next_rpt;
        w_code      = GEST_NONE;
        if (w_accept && i_req.level_sample) begin
            n_stable   = 1'b1;
            n_press_t  = w_now;
            n_next_rpt = w_now + {{(TIME_W-SPAN_W-1){1'b0}}, w_first_ofs};
            if (i_cfg.long_press_time == '0) begin
                n_long_sent = 1'b1;
                w_code      = GEST_LONG;
            end else begin
                n_long_sent = 1'b0;
            end
        end else if (w_accept) begin
            n_stable = 1'b0;
            if (!r_long_sent) begin
                w_code = GEST_SHORT;
            end
        end else if (r_stable) begin
            if (!r_long_sent && w_long_ok) begin
                n_long_sent = 1'b1;
                w_code      = GEST_LONG;
            end else if (r_long_sent && i_cfg.repeat_enable && w_rpt_ok) begin
                n_next_rpt = w_now + {{(TIME_W-SPAN_W){1'b0}}, i_cfg.repeat_interval};
                w_code     = GEST_REPEAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= 1'b0;
            r_chg_t     <= '0;
            r_stable    <= 1'b0;
            r_press_t   <= '0;
            r_long_sent <= 1'b0;
            r_next_rpt  <= '0;
        end else if (i_step) begin
            r_raw       <= n_raw;
            r_chg_t     <= n_chg_t;
            r_stable    <= n_stable;
            r_press_t   <= n_press_t;
            r_long_sent <= n_long_sent;
            r_next_rpt  <= n_next_rpt;
        end
    end

    assign o_res.gesture_code = w_code;
    assign o_res.held_level   = n_stable;

endmodule

`default_nettype wire

@@ hw/rtl/button_press_classifier_core.sv @@
// Top level of the button press classifier: input register, classifier
// step and result register. Depends on bpc_pkg, bpc_cfg and bpc_classify.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request per sample:
//   the raw level and a wrapping millisecond timestamp.
//   Output channel o_out_valid / i_out_ready returns exactly one result per
//   sample: the gesture code and the debounced level after that sample.
//   A request passes through two registers: it is taken into the input
//   register, then its result is written into the result register.
//   Throughput: one request per cycle unless the receiver stalls, set by the single
//   classification step (32-bit subtract and compare) between the two registers.
//   When the receiver stalls, the result holds and one more request can
//   wait in the input register; o_in_ready then drops.
//   Reset (i_rst_n low, synchronous) empties both registers, clears the
//   button state and loads the default timing registers.
//   The APB port is written with psel, penable, pwrite high; pready is tied
//   high. Write the registers only while no request is in flight.
`default_nettype none

module button_press_classifier_core
    import bpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  t_in_req                 i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_req                o_out_req,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg     w_cfg;
    t_in_req  r_in;
    logic     r_in_valid;
    t_out_req r_out, n_out;
    logic     r_out_valid;
    logic     w_out_free;
    logic     w_step;

    bpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    bpc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire
